// ===== sv/b2da_pkg.sv =====
// Package for the binary to decimal ASCII converter.
// Holds digit constants, the pipeline word type and the shift-and-add-3 step.
// No dependencies.
package b2da_pkg;

  localparam int BinWidth    = 32;
  localparam int NumDigits   = 10;
  localparam int BcdWidth    = 4 * NumDigits;
  localparam int BitsPerStep = 4;
  localparam int NumConv     = BinWidth / BitsPerStep;

  // ASCII '0' is 6'b11_0000, so a digit is placed under these two bits
  localparam logic [1:0] AsciiZeroHi = 2'b11;

  typedef struct packed {
    logic [BcdWidth-1:0] bcd;
    logic [BinWidth-1:0] bin;
  } conv_t;

  // Four shift-and-add-3 steps; bin shifts out its top bit into bcd
  function automatic conv_t dabble4(input conv_t w);
    conv_t t;
    t = w;
    for (int s = 0; s < BitsPerStep; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (t.bcd[4*d +: 4] >= 4'd5) begin
          t.bcd[4*d +: 4] = t.bcd[4*d +: 4] + 4'd3;
        end
      end
      t.bcd = {t.bcd[BcdWidth-2:0], t.bin[BinWidth-1]};
      t.bin = {t.bin[BinWidth-2:0], 1'b0};
    end
    return t;
  endfunction

  // Index of the most significant non-zero digit, zero for a zero value
  function automatic logic [3:0] top_digit(input logic [BcdWidth-1:0] bcd);
    logic [3:0] top;
    top = '0;
    for (int d = 1; d < NumDigits; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        top = 4'(d);
      end
    end
    return top;
  endfunction

endpackage

// ===== sv/binary_to_decimal_ascii.sv =====
// Binary to decimal ASCII converter, top level.
// Eight double-dabble stages, a digit count stage and a digit serialiser.
// Depends on b2da_pkg.
//
// Usage: present a 32-bit unsigned value on in_value with in_valid; the item
// is taken on a clock edge where in_valid is high and in_stall is low. For
// each value the block sends its decimal text on the out_ channel, one ASCII
// digit per item, most significant first, no leading zeros; a zero value
// gives the single digit '0'. out_last marks the least significant digit.
// Path: a value passes the 8 conversion stages, the count stage and the
// serialiser register before its first digit is shown. Throughput: the
// serialiser sends the n digits (1 to 10) of a value one digit per cycle
// while out_stall is low and takes the next value with the final digit;
// the pipeline behind it accepts a new value every cycle until it fills.
// When the receiver stalls, the current digit holds, the stages behind
// fill up and in_stall rises once all are full; nothing is lost or
// repeated. Reset (rst_n low, synchronous) empties every stage; there is
// no other state.
module binary_to_decimal_ascii (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [b2da_pkg::BinWidth-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [5:0]                   out_digit_char,
  output logic                         out_last
);
  import b2da_pkg::*;

  logic                vld_r  [NumConv];
  conv_t               conv_r [NumConv];
  logic                rdy    [NumConv+1];

  logic                cnt_vld_r;
  logic [BcdWidth-1:0] cnt_bcd_r;
  logic [3:0]          cnt_top_r;

  logic                ser_vld_r;
  logic [BcdWidth-1:0] ser_bcd_r;
  logic [3:0]          ser_idx_r;
  logic [3:0]          ser_idx_nxt;
  logic                ser_fire;
  logic                ser_rdy;

  conv_t               conv0_in;

  assign conv0_in = '{bcd: '0, bin: in_value};

  // Serialiser frees up on its final digit
  assign ser_fire = ser_vld_r && !out_stall;
  assign ser_rdy  = !ser_vld_r || (ser_fire && ser_idx_r == 4'd0);

  assign rdy[NumConv] = !cnt_vld_r || ser_rdy;
  assign in_stall     = !rdy[0];

  genvar g;
  generate
    for (g = 0; g < NumConv; g++) begin : g_conv
      assign rdy[g] = !vld_r[g] || rdy[g+1];

      if (g == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[g] <= 1'b0;
          end else if (rdy[g]) begin
            vld_r[g] <= in_valid;
          end
        end
        always_ff @(posedge clk) begin
          if (rdy[g]) begin
            conv_r[g] <= dabble4(conv0_in);
          end
        end
      end else begin : g_rest
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[g] <= 1'b0;
          end else if (rdy[g]) begin
            vld_r[g] <= vld_r[g-1];
          end
        end
        always_ff @(posedge clk) begin
          if (rdy[g]) begin
            conv_r[g] <= dabble4(conv_r[g-1]);
          end
        end
      end
    end
  endgenerate

  // Count stage: find the leading digit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= 1'b0;
    end else if (rdy[NumConv]) begin
      cnt_vld_r <= vld_r[NumConv-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NumConv]) begin
      cnt_bcd_r <= conv_r[NumConv-1].bcd;
      cnt_top_r <= top_digit(conv_r[NumConv-1].bcd);
    end
  end

  // Serialiser: load on a free slot, else count down on each sent digit
  always_comb begin
    ser_idx_nxt = ser_idx_r;
    if (ser_rdy) begin
      ser_idx_nxt = cnt_top_r;
    end else if (ser_fire) begin
      ser_idx_nxt = ser_idx_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
    end else if (ser_rdy) begin
      ser_vld_r <= cnt_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    ser_idx_r <= ser_idx_nxt;
    if (ser_rdy) begin
      ser_bcd_r <= cnt_bcd_r;
    end
  end

  assign out_valid      = ser_vld_r;
  assign out_digit_char = {AsciiZeroHi, ser_bcd_r[{ser_idx_r, 2'b00} +: 4]};
  assign out_last       = (ser_idx_r == 4'd0);

  // Empty first stage must never push back on the sender
  a_in_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> !in_stall)
    else $error("input stalled with an empty first stage");

  // A shown digit is a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= 6'd48 && out_digit_char <= 6'd57))
    else $error("digit out of range");

  // Serialiser index stays within the digit count
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ser_vld_r |-> ser_idx_r < 4'(NumDigits))
    else $error("serialiser index out of range");

  // A run of more than one digit never starts with a zero
  a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ser_rdy && cnt_vld_r && cnt_top_r != 4'd0) |=> out_digit_char != 6'd48)
    else $error("leading zero shown");

endmodule
